// ----- hw/rtl/json_string_unescape_utf8_unit_macros.svh -----
// assertion macros for the json string unescape unit
`ifndef JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// checked at every clock edge outside reset
`define JSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent, outside reset
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/jsu_pkg.sv -----
// types, codes and helpers shared by the json string unescape unit
`default_nettype none

package jsu_pkg;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);
  localparam int unsigned CP_W    = 21;

  // result status codes
  typedef enum logic [3:0] {
    ST_DATA        = 4'd0,
    ST_STR_END     = 4'd1,
    ST_NO_QUOTE    = 4'd2,
    ST_CTRL_BYTE   = 4'd3,
    ST_BAD_ESC     = 4'd4,
    ST_BAD_HEX     = 4'd5,
    ST_MISS_LOW    = 4'd6,
    ST_BAD_LOW     = 4'd7,
    ST_STRAY_LOW   = 4'd8,
    ST_UNTERM      = 4'd9,
    ST_INC_ESC     = 4'd10,
    ST_INC_UNICODE = 4'd11
  } status_e;

  // parser modes
  typedef enum logic [6:0] {
    MODE_IDLE = 7'b0000001,
    MODE_STR  = 7'b0000010,
    MODE_ESC  = 7'b0000100,
    MODE_HEX1 = 7'b0001000,
    MODE_BSL  = 7'b0010000,
    MODE_LU   = 7'b0100000,
    MODE_HEX2 = 7'b1000000
  } mode_e;

  // characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CC_BS    = 8'h08;
  localparam logic [7:0] CC_FF    = 8'h0c;
  localparam logic [7:0] CC_LF    = 8'h0a;
  localparam logic [7:0] CC_CR    = 8'h0d;
  localparam logic [7:0] CC_TAB   = 8'h09;

  // surrogate prefixes (top six bits of a quad)
  localparam logic [5:0] SURR_HIGH = 6'b110110;
  localparam logic [5:0] SURR_LOW  = 6'b110111;

  // utf-8 range limits and supplementary plane base
  localparam logic [CP_W-1:0] CP_MAX_1B = 21'h00007f;
  localparam logic [CP_W-1:0] CP_MAX_2B = 21'h0007ff;
  localparam logic [CP_W-1:0] CP_MAX_3B = 21'h00ffff;
  localparam logic [CP_W-1:0] CP_SUPP   = 21'h010000;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } item_t;

  typedef struct packed {
    item_t [MAX_RES-1:0] items;
    logic  [CNT_W-1:0]   count;
  } burst_t;

  // returns {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/jsu_if.sv -----
// input and output channels of the json string unescape unit
`default_nettype none

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_flag;

  modport source (output valid, output in_byte, output end_flag, input ready);
  modport sink   (input valid, input in_byte, input end_flag, output ready);
endinterface

interface jsu_out_if
  import jsu_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  status_e    status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/jsu_utf8_enc.sv -----
// code point to utf-8 byte group
`default_nettype none

module jsu_utf8_enc
  import jsu_pkg::*;
(
  input  logic [CP_W-1:0] cp_i,
  output burst_t          burst_o
);

  always_comb begin
    burst_o = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      burst_o.items[i].status = ST_DATA;
    end
    if (cp_i <= CP_MAX_1B) begin
      burst_o.items[0].out_byte = cp_i[7:0];
      burst_o.count = CNT_W'(1);
    end else if (cp_i <= CP_MAX_2B) begin
      burst_o.items[0].out_byte = {3'b110, cp_i[10:6]};
      burst_o.items[1].out_byte = {2'b10, cp_i[5:0]};
      burst_o.count = CNT_W'(2);
    end else if (cp_i <= CP_MAX_3B) begin
      burst_o.items[0].out_byte = {4'b1110, cp_i[15:12]};
      burst_o.items[1].out_byte = {2'b10, cp_i[11:6]};
      burst_o.items[2].out_byte = {2'b10, cp_i[5:0]};
      burst_o.count = CNT_W'(3);
    end else begin
      burst_o.items[0].out_byte = {5'b11110, cp_i[20:18]};
      burst_o.items[1].out_byte = {2'b10, cp_i[17:12]};
      burst_o.items[2].out_byte = {2'b10, cp_i[11:6]};
      burst_o.items[3].out_byte = {2'b10, cp_i[5:0]};
      burst_o.count = CNT_W'(4);
    end
    // flag the final byte of the group
    for (int i = 0; i < MAX_RES; i++) begin
      burst_o.items[i].last = (CNT_W'(i + 1) == burst_o.count);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_decode.sv -----
// escape parser: mode and hex state, result group per accepted byte
`default_nettype none

module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_flag_i,
  output burst_t     burst_o
);

  mode_e       mode_q, mode_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  dig_q, dig_d;
  logic [9:0]  hs_q, hs_d;

  logic [4:0]      hd;
  logic [15:0]     quad;
  logic            fail_en, one_en, utf_en;
  status_e         fail_st, one_st;
  logic [7:0]      one_byte;
  logic [CP_W-1:0] cp;
  burst_t          utf_burst;

  assign hd   = hex_digit(in_byte_i);
  assign quad = {hex_q[11:0], hd[3:0]};

  jsu_utf8_enc u_enc (
    .cp_i    (cp),
    .burst_o (utf_burst)
  );

  always_comb begin
    mode_d   = mode_q;
    hex_d    = hex_q;
    dig_d    = dig_q;
    hs_d     = hs_q;
    fail_en  = 1'b0;
    fail_st  = ST_DATA;
    one_en   = 1'b0;
    one_st   = ST_DATA;
    one_byte = 8'h00;
    utf_en   = 1'b0;
    cp       = {5'b0, quad};

    if (accept_i) begin
      if (end_flag_i) begin
        case (mode_q)
          MODE_STR: begin
            fail_en = 1'b1;
            fail_st = ST_UNTERM;
          end
          MODE_ESC: begin
            fail_en = 1'b1;
            fail_st = ST_INC_ESC;
          end
          MODE_HEX1, MODE_HEX2: begin
            fail_en = 1'b1;
            fail_st = ST_INC_UNICODE;
          end
          MODE_BSL, MODE_LU: begin
            fail_en = 1'b1;
            fail_st = ST_MISS_LOW;
          end
          default: begin
            mode_d = MODE_IDLE;
            hex_d  = '0;
            dig_d  = '0;
            hs_d   = '0;
          end
        endcase
      end else begin
        case (mode_q)
          MODE_STR: begin
            if (in_byte_i == CH_QUOTE) begin
              mode_d = MODE_IDLE;
              one_en = 1'b1;
              one_st = ST_STR_END;
            end else if (in_byte_i < CH_SPACE) begin
              fail_en = 1'b1;
              fail_st = ST_CTRL_BYTE;
            end else if (in_byte_i == CH_BSL) begin
              mode_d = MODE_ESC;
            end else begin
              one_en   = 1'b1;
              one_byte = in_byte_i;
            end
          end
          MODE_ESC: begin
            mode_d = MODE_STR;
            case (in_byte_i)
              CH_QUOTE, CH_BSL, CH_SLASH: begin
                one_en   = 1'b1;
                one_byte = in_byte_i;
              end
              CH_B: begin
                one_en   = 1'b1;
                one_byte = CC_BS;
              end
              CH_F: begin
                one_en   = 1'b1;
                one_byte = CC_FF;
              end
              CH_N: begin
                one_en   = 1'b1;
                one_byte = CC_LF;
              end
              CH_R: begin
                one_en   = 1'b1;
                one_byte = CC_CR;
              end
              CH_T: begin
                one_en   = 1'b1;
                one_byte = CC_TAB;
              end
              CH_U: begin
                mode_d = MODE_HEX1;
                hex_d  = '0;
                dig_d  = '0;
              end
              default: begin
                fail_en = 1'b1;
                fail_st = ST_BAD_ESC;
              end
            endcase
          end
          MODE_HEX1, MODE_HEX2: begin
            if (!hd[4]) begin
              fail_en = 1'b1;
              fail_st = ST_BAD_HEX;
            end else if (dig_q != 2'd3) begin
              hex_d = quad;
              dig_d = dig_q + 2'd1;
            end else begin
              hex_d = '0;
              dig_d = '0;
              if (mode_q == MODE_HEX1) begin
                if (quad[15:10] == SURR_HIGH) begin
                  hs_d   = quad[9:0];
                  mode_d = MODE_BSL;
                end else if (quad[15:10] == SURR_LOW) begin
                  fail_en = 1'b1;
                  fail_st = ST_STRAY_LOW;
                end else begin
                  mode_d = MODE_STR;
                  utf_en = 1'b1;
                end
              end else begin
                if (quad[15:10] != SURR_LOW) begin
                  fail_en = 1'b1;
                  fail_st = ST_BAD_LOW;
                end else begin
                  // join the pair: plane base plus the twenty payload bits
                  mode_d = MODE_STR;
                  hs_d   = '0;
                  utf_en = 1'b1;
                  cp     = CP_SUPP + {1'b0, hs_q, quad[9:0]};
                end
              end
            end
          end
          MODE_BSL: begin
            if (in_byte_i != CH_BSL) begin
              fail_en = 1'b1;
              fail_st = ST_MISS_LOW;
            end else begin
              mode_d = MODE_LU;
            end
          end
          MODE_LU: begin
            if (in_byte_i != CH_U) begin
              fail_en = 1'b1;
              fail_st = ST_MISS_LOW;
            end else begin
              mode_d = MODE_HEX2;
              hex_d  = '0;
              dig_d  = '0;
            end
          end
          default: begin
            hex_d = '0;
            dig_d = '0;
            hs_d  = '0;
            if (in_byte_i == CH_QUOTE) begin
              mode_d = MODE_STR;
            end else begin
              mode_d = MODE_IDLE;
              one_en = 1'b1;
              one_st = ST_NO_QUOTE;
            end
          end
        endcase
      end
    end

    // any error drops back to idle with the hex state cleared
    if (fail_en) begin
      mode_d   = MODE_IDLE;
      hex_d    = '0;
      dig_d    = '0;
      hs_d     = '0;
      one_en   = 1'b1;
      one_st   = fail_st;
      one_byte = 8'h00;
    end
  end

  always_comb begin
    burst_o = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      burst_o.items[i].status = ST_DATA;
    end
    if (utf_en) begin
      burst_o = utf_burst;
    end else if (one_en) begin
      burst_o.items[0].out_byte = one_byte;
      burst_o.items[0].status   = one_st;
      burst_o.items[0].last     = 1'b1;
      burst_o.count             = CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      hex_q  <= '0;
      dig_q  <= '0;
      hs_q   <= '0;
    end else begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      dig_q  <= dig_d;
      hs_q   <= hs_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/jsu_burst.sv -----
// result register: holds one result group and hands it out a byte a cycle while out_o is ready
`default_nettype none

module jsu_burst
  import jsu_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  burst_t burst_i,
  output logic   can_load_o,
  jsu_out_if.source out_o
);

`include "json_string_unescape_utf8_unit_macros.svh"

  item_t [MAX_RES-1:0] items_q;
  logic  [CNT_W-1:0]   cnt_q;
  logic  [IDX_W-1:0]   idx_q;
  logic                pop;
  item_t               cur;

  assign cur        = items_q[idx_q];
  assign pop        = (cnt_q != '0) && out_o.ready;
  // free now, or the final waiting result leaves this cycle
  assign can_load_o = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_o.ready);

  assign out_o.valid    = (cnt_q != '0);
  assign out_o.out_byte = cur.out_byte;
  assign out_o.status   = cur.status;
  assign out_o.last     = cur.last;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      items_q <= burst_i.items;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      cnt_q <= burst_i.count;
      idx_q <= '0;
    end else if (pop) begin
      cnt_q <= cnt_q - CNT_W'(1);
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  `JSU_ASSERT(a_final_is_last, (cnt_q != CNT_W'(1)) || cur.last, "final result of group lacks last")
  `JSU_ASSERT(a_idx_in_range, (CNT_W'(idx_q) + cnt_q) <= CNT_W'(MAX_RES), "group index overrun")
  `JSU_ASSERT_NEXT(a_drain_done, pop && (cnt_q == CNT_W'(1)), (cnt_q == '0) || $past(load_i), "stale results after last")

endmodule

`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8_unit.sv -----
// top level of the json string unescape to utf-8 unit
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   in_byte[7:0], end_flag
//   out_o    out  valid/ready   out_byte[7:0], status[3:0], last
//
// one source byte (or end mark) is taken per cycle while in_i.ready is high; the
// parser state advances at the request and the result group (0 to 4 results)
// lands in the result register in the same edge.
// the result register hands out one result per cycle while out_o is ready, so a
// multi-byte utf-8 group holds off the next request until its final byte is
// shown, even with out_o always ready; a \uXXXX escape spans six or more source
// bytes, and only its final byte loads a result group.
// rst_ni clears the parser to idle and empties the result register.
// in_i.ready is low while a result waits behind the one being shown, or while
// the one being shown is stalled on out_o.
`default_nettype none

module json_string_unescape_utf8_unit
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic   accept;
  logic   can_load;
  burst_t burst;

  // request taken when the result register can take its group
  assign in_i.ready = can_load;
  assign accept     = in_i.valid && can_load;

  // parser: escape and surrogate handling, utf-8 encoding
  jsu_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_i.in_byte),
    .end_flag_i (in_i.end_flag),
    .burst_o    (burst)
  );

  // result register and output sequencing
  jsu_burst u_burst (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .burst_i    (burst),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
